// ===== rtl/core/cnlc_pkg.sv =====
// ----------------------------------------------------------------------------
// cnlc_pkg
// Shared types, constants and helper functions of the card number Luhn
// classifier: the binary-to-BCD conversion word, result codes and the
// digit weighting used by the checksum.
// ----------------------------------------------------------------------------
package cnlc_pkg;

	// Width of the binary card number and of its decimal form.
	localparam int unsigned BIN_W        = 54;
	localparam int unsigned BCD_DIGITS   = 17;
	localparam int unsigned BCD_W        = 4 * BCD_DIGITS;
	localparam int unsigned DIGIT_COUNT  = 16;
	localparam int unsigned SUM_W        = 8;
	localparam int unsigned PAIR_W       = 5;
	localparam int unsigned QUAD_W       = 7;

	// Result codes of card_kind.
	typedef enum logic [1:0] {
		KIND_INVALID = 2'd0,
		KIND_FIFTEEN = 2'd1,
		KIND_SIXTEEN = 2'd2,
		KIND_FOUR    = 2'd3
	} kind_t;

	typedef logic [3:0] digit_t;

	// Word handed from one conversion cell to the next.
	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [BIN_W-1:0] bin;
	} dabble_t;

	// Weight of one digit: digits at odd positions are doubled, and nine is
	// taken off a double above nine.
	function automatic logic [PAIR_W-1:0] luhn_weight(input digit_t d, input logic odd);
		logic [PAIR_W-1:0] dbl;
		dbl = {d, 1'b0};
		if (!odd) begin
			return PAIR_W'(d);
		end else if (dbl > PAIR_W'(9)) begin
			return dbl - PAIR_W'(9);
		end else begin
			return dbl;
		end
	endfunction

	// True when the sum is a multiple of ten (sums stay below 180).
	function automatic logic is_mult10(input logic [SUM_W-1:0] s);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < 18; k++) begin
			if (s == SUM_W'(k * 10)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// Issuer class from length and leading digits, before the Luhn gate.
	function automatic kind_t classify(input logic [BCD_W-1:0] bcd);
		digit_t d12, d13, d14, d15, d16;
		logic   z16;
		d12 = bcd[4*12 +: 4];
		d13 = bcd[4*13 +: 4];
		d14 = bcd[4*14 +: 4];
		d15 = bcd[4*15 +: 4];
		d16 = bcd[4*16 +: 4];
		z16 = (d16 == 4'd0);
		if (z16 && d15 == 4'd0 && d14 == 4'd3 && (d13 == 4'd4 || d13 == 4'd7)) begin
			return KIND_FIFTEEN;
		end else if (z16 && d15 == 4'd5 && d14 >= 4'd1 && d14 <= 4'd5) begin
			return KIND_SIXTEEN;
		end else if ((z16 && d15 == 4'd0 && d14 == 4'd0 && d13 == 4'd0 && d12 == 4'd4)
				|| (z16 && d15 == 4'd4)) begin
			return KIND_FOUR;
		end else begin
			return KIND_INVALID;
		end
	endfunction

endpackage

// ===== rtl/core/cnlc_dabble_cell.sv =====
// ----------------------------------------------------------------------------
// cnlc_dabble_cell
// One step of the binary-to-BCD conversion: every BCD digit of five or more
// gets three added, then the top binary bit is shifted into the BCD word.
// ----------------------------------------------------------------------------
module cnlc_dabble_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  cnlc_pkg::dabble_t up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output cnlc_pkg::dabble_t dn_data
);
	import cnlc_pkg::*;

	logic    valid_q;
	dabble_t data_q;
	dabble_t step;
	logic [BCD_W-1:0] adj;

	// Correct each digit, then shift one bit across.
	always_comb begin
		for (int j = 0; j < BCD_DIGITS; j++) begin
			if (up_data.bcd[4*j +: 4] >= 4'd5) begin
				adj[4*j +: 4] = up_data.bcd[4*j +: 4] + 4'd3;
			end else begin
				adj[4*j +: 4] = up_data.bcd[4*j +: 4];
			end
		end
		step.bcd = {adj[BCD_W-2:0], up_data.bin[BIN_W-1]};
		step.bin = {up_data.bin[BIN_W-2:0], 1'b0};
	end

	// The cell takes an item when it is empty or its item moves on.
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= step;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

// ===== rtl/core/cnlc_sum_tree.sv =====
// ----------------------------------------------------------------------------
// cnlc_sum_tree
// Three-stage registered adder tree that forms the Luhn sum over the sixteen
// low digits, checks it for a multiple of ten and gates the issuer class.
// ----------------------------------------------------------------------------
module cnlc_sum_tree (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  logic [cnlc_pkg::BCD_W-1:0] up_bcd,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output cnlc_pkg::kind_t            dn_kind,
	output logic                       dn_ok,
	output logic [cnlc_pkg::SUM_W-1:0] dn_sum
);
	import cnlc_pkg::*;

	localparam int unsigned PAIRS = DIGIT_COUNT / 2;
	localparam int unsigned QUADS = 2;
	localparam int unsigned PER_Q = PAIRS / QUADS;

	logic                  valid_s1, valid_s2, valid_s3;
	logic                  rdy_s1, rdy_s2, rdy_s3;
	logic [PAIR_W-1:0]     pair_s1 [PAIRS];
	kind_t                 kind_s1, kind_s2, kind_s3;
	logic [QUAD_W-1:0]     quad_s2 [QUADS];
	logic [SUM_W-1:0]      sum_s3;
	logic                  ok_s3;
	logic [PAIR_W-1:0]     pair_d   [PAIRS];
	logic [QUAD_W-1:0]     quad_d   [QUADS];
	logic [SUM_W-1:0]      sum_d;

	// Ready chain, back to front.
	assign rdy_s3   = !valid_s3 || dn_ready;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	// Weighted digit pairs: even position plain, odd position doubled.
	always_comb begin
		for (int k = 0; k < PAIRS; k++) begin
			pair_d[k] = luhn_weight(up_bcd[4*(2*k) +: 4], 1'b0)
				+ luhn_weight(up_bcd[4*(2*k+1) +: 4], 1'b1);
		end
	end

	// Pairs folded into two partial sums.
	always_comb begin
		for (int m = 0; m < QUADS; m++) begin
			quad_d[m] = '0;
			for (int k = 0; k < PER_Q; k++) begin
				quad_d[m] = quad_d[m] + QUAD_W'(pair_s1[m*PER_Q + k]);
			end
		end
	end

	assign sum_d = SUM_W'(quad_s2[0]) + SUM_W'(quad_s2[1]);

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= up_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			pair_s1 <= pair_d;
			kind_s1 <= classify(up_bcd);
		end
		if (rdy_s2 && valid_s1) begin
			quad_s2 <= quad_d;
			kind_s2 <= kind_s1;
		end
		if (rdy_s3 && valid_s2) begin
			sum_s3  <= sum_d;
			ok_s3   <= is_mult10(sum_d);
			kind_s3 <= is_mult10(sum_d) ? kind_s2 : KIND_INVALID;
		end
	end

	assign dn_valid = valid_s3;
	assign dn_kind  = kind_s3;
	assign dn_ok    = ok_s3;
	assign dn_sum   = sum_s3;

endmodule

// ===== rtl/core/card_number_luhn_classifier_core.sv =====
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_core
// Accepts one card number per clock cycle when the output side does not stall,
// and returns one result per number, in order: a row of 54 conversion cells
// turns the binary number into decimal digits, one input bit per cell, and a
// three-stage adder tree forms the Luhn sum, the pass flag and the issuer
// class. Every stage holds one item, so up to 57 numbers are in flight and a
// stalled result only holds the stages that are full behind it.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       card_valid,
	output logic                       card_ready,
	input  logic [cnlc_pkg::BIN_W-1:0] card_number,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [1:0]                 card_kind,
	output logic                       luhn_ok,
	output logic [cnlc_pkg::SUM_W-1:0] digit_sum
);
	import cnlc_pkg::*;

	logic    cell_valid [BIN_W+1];
	logic    cell_ready [BIN_W+1];
	dabble_t cell_data  [BIN_W+1];
	kind_t   kind;

	// Entry of the conversion row.
	assign cell_valid[0] = card_valid;
	assign card_ready    = cell_ready[0];
	assign cell_data[0]  = '{bcd: '0, bin: card_number};

	// Binary-to-BCD row, one bit per cell.
	for (genvar i = 0; i < BIN_W; i++) begin : g_cell
		cnlc_dabble_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cell_valid[i]),
			.up_ready (cell_ready[i]),
			.up_data  (cell_data[i]),
			.dn_valid (cell_valid[i+1]),
			.dn_ready (cell_ready[i+1]),
			.dn_data  (cell_data[i+1])
		);
	end

	// Checksum and classification.
	cnlc_sum_tree u_tree (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cell_valid[BIN_W]),
		.up_ready (cell_ready[BIN_W]),
		.up_bcd   (cell_data[BIN_W].bcd),
		.dn_valid (result_valid),
		.dn_ready (result_ready),
		.dn_kind  (kind),
		.dn_ok    (luhn_ok),
		.dn_sum   (digit_sum)
	);

	assign card_kind = kind;

`ifndef SYNTHESIS
	// A free output side never holds back the input side.
	a_ready_path: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> card_ready)
		else $error("card_ready low while result_ready is high");

	// A failed checksum always yields the invalid class.
	a_fail_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !luhn_ok) |-> (card_kind == KIND_INVALID))
		else $error("class given to a number that fails the checksum");

	// The weighted sum of sixteen digits cannot exceed 144.
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (digit_sum <= SUM_W'(144)))
		else $error("digit_sum out of range");
`endif

endmodule

// ===== tb/card_number_luhn_classifier_core_test.sv =====
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_core_test
// Self-checking testbench of the card number Luhn classifier. Card numbers are
// sent over the input handshake and the expected digit sum, pass flag and
// issuer class of each item are worked out by a local predictor. Every result
// is compared in order against the oldest pending expectation. The run covers
// directed corner numbers, well-formed random card numbers with a minority of
// raw values, uneven idling on both sides, and a long output stall.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cnlc_pkg::*;

	// Decimal scales used to find the leading digits of a number.
	localparam longint unsigned LEAD_13 = 64'd1000000000000;
	localparam longint unsigned LEAD_15 = 64'd10000000000000;
	localparam longint unsigned LEAD_16 = 64'd100000000000000;
	localparam longint unsigned LEAD_16_ONE = 64'd1000000000000000;
	localparam longint unsigned SEVENTEEN_LOW = 64'd10000000000000000;
	localparam longint unsigned SEVENTEEN_SPAN = 64'd8014398509481983;
	localparam int unsigned LUHN_DIGITS = 16;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		kind_t      kind;
		logic       ok;
		logic [7:0] sum;
	} card_grade_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              card_valid = 1'b0;
	logic              card_ready;
	logic [BIN_W-1:0]  card_number = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	logic [1:0]        card_kind;
	logic              luhn_ok;
	logic [SUM_W-1:0]  digit_sum;

	card_grade_t pending_grades[$];
	int          mismatch_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int          hold_left = 0;

	card_number_luhn_classifier_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.card_valid   (card_valid),
		.card_ready   (card_ready),
		.card_number  (card_number),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.card_kind    (card_kind),
		.luhn_ok      (luhn_ok),
		.digit_sum    (digit_sum)
	);

	// Free-running clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Grades one card number: Luhn sum of the sixteen low digits, then the
	// issuer class when the sum is a multiple of ten.
	function automatic card_grade_t grade_card(input logic [BIN_W-1:0] number);
		card_grade_t     grade;
		longint unsigned rest;
		longint unsigned value;
		int unsigned     digit;
		int unsigned     total;
		value = 64'(number);
		rest = value;
		total = 0;
		for (int pos = 0; pos < LUHN_DIGITS; pos++) begin
			digit = 32'(rest % 10);
			rest = rest / 10;
			if (pos % 2 == 1) begin
				digit = digit * 2;
				if (digit > 9) begin
					digit = digit - 9;
				end
			end
			total += digit;
		end
		grade.sum = total[7:0];
		grade.ok = (total % 10 == 0);
		if (!grade.ok) begin
			grade.kind = KIND_INVALID;
		end else if (value / LEAD_15 == 34 || value / LEAD_15 == 37) begin
			grade.kind = KIND_FIFTEEN;
		end else if (value / LEAD_16 >= 51 && value / LEAD_16 <= 55) begin
			grade.kind = KIND_SIXTEEN;
		end else if (value / LEAD_13 == 4 || value / LEAD_16_ONE == 4) begin
			grade.kind = KIND_FOUR;
		end else begin
			grade.kind = KIND_INVALID;
		end
		return grade;
	endfunction

	// Builds a number of the given length behind a prefix, with random middle
	// digits and a check digit that makes the Luhn test pass or fail.
	function automatic logic [BIN_W-1:0] build_card(input int unsigned prefix,
			input int unsigned prefix_len, input int unsigned length, input bit luhn_pass);
		longint unsigned value;
		card_grade_t     partial;
		int unsigned     rem;
		value = 64'(prefix);
		for (int unsigned i = prefix_len; i + 1 < length; i++) begin
			value = value * 10 + 64'($urandom_range(9));
		end
		value = value * 10;
		partial = grade_card(value[BIN_W-1:0]);
		rem = 32'(partial.sum) % 10;
		if (luhn_pass) begin
			value += 64'((10 - rem) % 10);
		end else begin
			value += 64'((10 - rem + $urandom_range(1, 9)) % 10);
		end
		return value[BIN_W-1:0];
	endfunction

	// Random card number: half well-formed issuer numbers and near misses,
	// the rest raw values, over-long numbers and numbers of any length.
	function automatic logic [BIN_W-1:0] pick_card();
		bit              pass_luhn;
		longint unsigned raw;
		pass_luhn = ($urandom_range(99) < 75);
		raw = {$urandom, $urandom};
		case ($urandom_range(9))
			0: return build_card($urandom_range(1) ? 37 : 34, 2, 15, pass_luhn);
			1: return build_card($urandom_range(51, 55), 2, 16, pass_luhn);
			2: return build_card(4, 1, 16, pass_luhn);
			3: return build_card(4, 1, 13, pass_luhn);
			4: return build_card($urandom_range(10, 99), 2, $urandom_range(12, 16), pass_luhn);
			5: return build_card($urandom_range(1, 9), 1, $urandom_range(2, 16), pass_luhn);
			6: return raw[BIN_W-1:0];
			7: return build_card($urandom_range(9), 1, 16, pass_luhn);
			8: begin
				raw = SEVENTEEN_LOW + raw % SEVENTEEN_SPAN;
				return raw[BIN_W-1:0];
			end
			default: begin
				// Right prefix, wrong length.
				case ($urandom_range(3))
					0: return build_card($urandom_range(1) ? 37 : 34, 2, 14, pass_luhn);
					1: return build_card($urandom_range(51, 55), 2, 15, pass_luhn);
					2: return build_card(4, 1, $urandom_range(14, 15), pass_luhn);
					default: return build_card(4, 1, 12, pass_luhn);
				endcase
			end
		endcase
	endfunction

	// Sends one item, idling at random beforehand, and records its grade once
	// the block has taken it.
	task automatic send_card(input logic [BIN_W-1:0] number);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			card_valid <= 1'b0;
			@(negedge clk);
		end
		card_valid <= 1'b1;
		card_number <= number;
		do @(posedge clk); while (!card_ready);
		pending_grades.push_back(grade_card(number));
	endtask

	// Drops the input valid after the last item of a burst.
	task automatic park_sender();
		@(negedge clk);
		card_valid <= 1'b0;
	endtask

	// Waits until every pending result has come out, or the cycle bound runs out.
	task automatic wait_for_results(input int max_cycles);
		int waited;
		waited = 0;
		while (pending_grades.size() != 0 && waited < max_cycles) begin
			@(posedge clk);
			waited++;
		end
	endtask

	task automatic report_mismatch(input string text);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t: mismatch: %s", $realtime, text);
		end
	endtask

	// Output ready: long hold-off when one is requested, random stalls otherwise.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Compares every accepted result with the oldest pending grade.
	always @(posedge clk) begin
		card_grade_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_grades.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0d ok=%0d sum=%0d",
					card_kind, luhn_ok, digit_sum));
			end else begin
				want = pending_grades.pop_front();
				if (card_kind !== want.kind || luhn_ok !== want.ok
						|| digit_sum !== want.sum) begin
					report_mismatch($sformatf(
						"expected kind=%0d ok=%0d sum=%0d, got kind=%0d ok=%0d sum=%0d",
						want.kind, want.ok, want.sum, card_kind, luhn_ok, digit_sum));
				end
			end
		end
	end

	// Corner numbers: zero, widest input, over-long numbers, each issuer class,
	// prefix and length boundaries, and Luhn failures behind a good prefix.
	task automatic test_directed();
		logic [BIN_W-1:0] all_ones;
		longint unsigned  big;
		all_ones = '1;
		send_card('0);
		send_card(all_ones);
		big = 64'd9999999999999999;
		send_card(big[BIN_W-1:0]);
		big = SEVENTEEN_LOW;
		send_card(big[BIN_W-1:0]);
		send_card(54'd18);
		send_card(build_card(34, 2, 15, 1'b1));
		send_card(build_card(37, 2, 15, 1'b1));
		send_card(build_card(51, 2, 16, 1'b1));
		send_card(build_card(55, 2, 16, 1'b1));
		send_card(build_card(4, 1, 16, 1'b1));
		send_card(build_card(4, 1, 13, 1'b1));
		send_card(build_card(50, 2, 16, 1'b1));
		send_card(build_card(56, 2, 16, 1'b1));
		send_card(build_card(33, 2, 15, 1'b1));
		send_card(build_card(35, 2, 15, 1'b1));
		send_card(build_card(4, 1, 12, 1'b1));
		send_card(build_card(4, 1, 14, 1'b1));
		send_card(build_card(4, 1, 15, 1'b1));
		send_card(build_card(34, 2, 16, 1'b1));
		send_card(build_card(51, 2, 15, 1'b1));
		send_card(build_card(4, 1, 16, 1'b0));
		send_card(build_card(37, 2, 15, 1'b0));
		send_card(build_card(53, 2, 16, 1'b0));
		park_sender();
	endtask

	// Random items under a given pair of idle rates.
	task automatic test_random(input int count, input int unsigned idle_pct,
			input int unsigned stall_pct);
		send_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			send_card(pick_card());
		end
		park_sender();
	endtask

	// The output is held off long enough for the pipeline to fill and stall the
	// input; afterwards the sender pauses until every result is back.
	task automatic test_backpressure();
		send_idle_pct = 0;
		sink_stall_pct = 0;
		@(negedge clk);
		hold_left = 300;
		for (int i = 0; i < 150; i++) begin
			send_card(pick_card());
		end
		park_sender();
		wait_for_results(20000);
		for (int i = 0; i < 20; i++) begin
			send_card(pick_card());
		end
		park_sender();
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 10;
		sink_stall_pct = 71;
		test_directed();
		test_random(650, 10, 71);
		test_random(650, 71, 10);
		test_backpressure();
		test_random(460, 0, 0);
		wait_for_results(20000);
		repeat (80) @(posedge clk);
		if (mismatch_count == 0 && pending_grades.size() == 0) begin
			$display("PASS card_number_luhn_classifier_core");
		end else begin
			$display("FAIL card_number_luhn_classifier_core");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2000000;
		$display("FAIL card_number_luhn_classifier_core");
		$finish;
	end

endmodule
